// ===== src/fwms_pkg.sv =====
// ----------------------------------------------------------------------------
// fwms_pkg: shared types and constants of the queue with minimum service
// Request and response layouts, operation and status codes, the sequencer
// states and the circular slot arithmetic used by the engine.
// ----------------------------------------------------------------------------
package fwms_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_ENQUEUE  = 2'd0,
    OP_DEQUEUE  = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_SERVE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic                     found;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] head_value;
    logic                     is_empty;
  } out_t;

  // Store slot of the entry at logical position pos (pos is below DEPTH).
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [CNT_W-1:0]  pos);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, head} + {1'b0, pos};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] head);
    logic [ADDR_W-1:0] nxt;
    if (head == ADDR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = head + ADDR_W'(1);
    end
    return nxt;
  endfunction

endpackage

// ===== src/fifo_with_min_service_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_with_min_service_unit: bounded queue with extract-minimum service
// A queue of up to DEPTH signed words in a circular RAM. Each request asks to
// enqueue, dequeue the head, test membership, or serve (remove) the earliest
// smallest entry while keeping the order of the rest. Every request yields
// one response with the count, head value and empty flag after the operation.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------
//   in      | input     | in_valid / in_stall   | in_data  (fwms_pkg::in_t)
//   out     | output    | out_valid / out_stall | out_data (fwms_pkg::out_t)
//
// A full enqueue, or a dequeue or serve of an empty queue, goes straight to
// the response. A serve whose minimum sits behind the head walks the
// single read port of the entry RAM once for the scan and once more
// for the shift that closes the gap.
// Reset is synchronous; it empties the queue. The RAM contents are not
// cleared, since only live entries are ever read.
// in_stall is high while a request is being worked on. A finished response
// waits in the output register, so a stall on the out side holds only that
// register and the next request is already accepted behind it.
// ----------------------------------------------------------------------------
module fifo_with_min_service_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  fwms_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fwms_pkg::out_t  out_data
);

  logic           res_valid;
  logic           res_taken;
  fwms_pkg::out_t res;

  // The engine hands over its response as soon as the output register is
  // free or is being emptied in this same cycle.
  assign res_taken = res_valid && (!out_valid || !out_stall);

  fwms_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req       (in_data),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The payload only loads on a handoff, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_data <= res;
    end
  end

endmodule

// ===== src/fwms_ram.sv =====
// ----------------------------------------------------------------------------
// fwms_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds its
// value on cycles without a read.
// ----------------------------------------------------------------------------
module fwms_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/fwms_engine.sv =====
// ----------------------------------------------------------------------------
// fwms_engine: sequencer and datapath of the queue
// Holds head and count, walks the entry RAM with a one-deep read pipeline for
// scans and order-keeping shifts, and presents one response per request.
// ----------------------------------------------------------------------------
module fwms_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  fwms_pkg::in_t   req,
  output logic            res_valid,
  input  logic            res_taken,
  output fwms_pkg::out_t  res
);

  fwms_pkg::state_t state, state_next;

  logic [fwms_pkg::ADDR_W-1:0] head;
  logic [fwms_pkg::CNT_W-1:0]  count;
  fwms_pkg::op_t               op;
  logic signed [fwms_pkg::DATA_W-1:0] value;
  logic [fwms_pkg::CNT_W-1:0]  scan_end;
  logic [fwms_pkg::CNT_W-1:0]  issue_pos;
  logic                        pend;
  logic [fwms_pkg::CNT_W-1:0]  pend_pos;
  logic signed [fwms_pkg::DATA_W-1:0] best;
  logic [fwms_pkg::CNT_W-1:0]  best_pos;
  logic                        found;
  fwms_pkg::status_t           status;
  logic signed [fwms_pkg::DATA_W-1:0] result;
  logic signed [fwms_pkg::DATA_W-1:0] head_val;

  logic                        rd_en;
  logic [fwms_pkg::ADDR_W-1:0] rd_addr;
  logic [fwms_pkg::DATA_W-1:0] rd_data;
  logic                        wr_en;
  logic [fwms_pkg::ADDR_W-1:0] wr_addr;
  logic [fwms_pkg::DATA_W-1:0] wr_data;

  logic accept;
  logic scan_done;
  logic shift_done;
  fwms_pkg::op_t req_op;

  fwms_ram #(
    .WIDTH (fwms_pkg::DATA_W),
    .WORDS (fwms_pkg::DEPTH),
    .AW    (fwms_pkg::ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_op     = fwms_pkg::op_t'(req.operation);
  assign accept     = req_valid && (state == fwms_pkg::S_IDLE);
  assign scan_done  = (issue_pos == scan_end) && !pend;
  assign shift_done = (issue_pos == count) && !pend;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fwms_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (req_op)
            fwms_pkg::OP_ENQUEUE: begin
              state_next = (count == fwms_pkg::CNT_W'(fwms_pkg::DEPTH)) ?
                           fwms_pkg::S_DONE : fwms_pkg::S_HEAD_RD;
            end
            default: begin
              state_next = (count == '0) ? fwms_pkg::S_DONE : fwms_pkg::S_SCAN;
            end
          endcase
        end
      end
      fwms_pkg::S_SCAN: begin
        if (scan_done) begin
          if (op == fwms_pkg::OP_CONTAINS) begin
            state_next = fwms_pkg::S_DONE;
          end else if (best_pos == '0) begin
            state_next = fwms_pkg::S_HEAD_RD;
          end else begin
            state_next = fwms_pkg::S_SHIFT;
          end
        end
      end
      fwms_pkg::S_SHIFT: begin
        if (shift_done) begin
          state_next = fwms_pkg::S_HEAD_RD;
        end
      end
      fwms_pkg::S_HEAD_RD:   state_next = fwms_pkg::S_HEAD_WAIT;
      fwms_pkg::S_HEAD_WAIT: state_next = fwms_pkg::S_DONE;
      fwms_pkg::S_DONE: begin
        if (res_taken) begin
          state_next = fwms_pkg::S_IDLE;
        end
      end
      default: state_next = fwms_pkg::S_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = fwms_pkg::slot_of(head, issue_pos);
    wr_en   = 1'b0;
    wr_addr = fwms_pkg::slot_of(head, pend_pos - fwms_pkg::CNT_W'(1));
    wr_data = rd_data;
    unique case (state)
      fwms_pkg::S_IDLE: begin
        wr_addr = fwms_pkg::slot_of(head, count);
        wr_data = req.value;
        wr_en   = req_valid && (req_op == fwms_pkg::OP_ENQUEUE) &&
                  (count != fwms_pkg::CNT_W'(fwms_pkg::DEPTH));
      end
      fwms_pkg::S_SCAN: begin
        rd_en = (issue_pos < scan_end);
      end
      fwms_pkg::S_SHIFT: begin
        rd_en = (issue_pos < count);
        wr_en = pend;
      end
      fwms_pkg::S_HEAD_RD: begin
        rd_en   = 1'b1;
        rd_addr = head;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign req_stall = (state != fwms_pkg::S_IDLE);
  assign res_valid = (state == fwms_pkg::S_DONE);

  assign res.result_value = result;
  assign res.status       = status;
  assign res.found        = found;
  assign res.count        = count;
  assign res.head_value   = (count == '0) ? '0 : head_val;
  assign res.is_empty     = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwms_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= ((state == fwms_pkg::S_SCAN) || (state == fwms_pkg::S_SHIFT)) && rd_en;
      if (accept) begin
        if ((req_op == fwms_pkg::OP_ENQUEUE) &&
            (count != fwms_pkg::CNT_W'(fwms_pkg::DEPTH))) begin
          count <= count + fwms_pkg::CNT_W'(1);
        end
      end
      if ((state == fwms_pkg::S_SCAN) && scan_done && (op != fwms_pkg::OP_CONTAINS)) begin
        if (best_pos == '0) begin
          head  <= fwms_pkg::slot_inc(head);
          count <= count - fwms_pkg::CNT_W'(1);
        end
      end
      if ((state == fwms_pkg::S_SHIFT) && shift_done) begin
        count <= count - fwms_pkg::CNT_W'(1);
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_val <= '0;
    end else begin
      if (accept) begin
        op        <= req_op;
        value     <= req.value;
        issue_pos <= '0;
        found     <= 1'b0;
        result    <= '0;
        scan_end  <= (req_op == fwms_pkg::OP_DEQUEUE) ? fwms_pkg::CNT_W'(1) : count;
        if ((req_op == fwms_pkg::OP_ENQUEUE) &&
            (count == fwms_pkg::CNT_W'(fwms_pkg::DEPTH))) begin
          status <= fwms_pkg::STAT_FULL;
        end else if (((req_op == fwms_pkg::OP_DEQUEUE) ||
                      (req_op == fwms_pkg::OP_SERVE)) && (count == '0)) begin
          status <= fwms_pkg::STAT_EMPTY;
        end else begin
          status <= fwms_pkg::STAT_OK;
        end
      end
      if ((state == fwms_pkg::S_SCAN) || (state == fwms_pkg::S_SHIFT)) begin
        pend_pos <= issue_pos;
        if (rd_en) begin
          issue_pos <= issue_pos + fwms_pkg::CNT_W'(1);
        end
      end
      if ((state == fwms_pkg::S_SCAN) && pend) begin
        if (op == fwms_pkg::OP_CONTAINS) begin
          if (rd_data == value) begin
            found <= 1'b1;
          end
        end else if ((pend_pos == '0) || ($signed(rd_data) < best)) begin
          best     <= rd_data;
          best_pos <= pend_pos;
        end
      end
      if ((state == fwms_pkg::S_SCAN) && scan_done && (op != fwms_pkg::OP_CONTAINS)) begin
        result    <= best;
        issue_pos <= best_pos + fwms_pkg::CNT_W'(1);
      end
      if (state == fwms_pkg::S_HEAD_WAIT) begin
        head_val <= rd_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fwms_pkg::CNT_W'(fwms_pkg::DEPTH))
    else $error("entry count above capacity");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry in one cycle");

  a_shift_spares_head: assert property (@(posedge clk) disable iff (rst)
    ((state == fwms_pkg::S_SHIFT) && wr_en) |-> (wr_addr != head))
    else $error("shift wrote over the head entry");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    ((state == fwms_pkg::S_DONE) && !res_taken) |=> (state == fwms_pkg::S_DONE))
    else $error("response dropped before it was taken");
`endif

endmodule
